FILE: sv/sdtq_pkg.sv
// Shared types, codes and sizes for the sorted deadline timer queue.
`default_nettype none

package sdtq_pkg;

  // Queue size and per-tick expiry limit.
  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

  // Command codes.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_ADDED     = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_FIRED     = 3'd2;
  localparam logic [2:0] KIND_DELETED   = 3'd3;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd4;

  // Input item.
  typedef struct packed {
    logic [1:0]  command;
    logic [29:0] delay_ms;
    logic [30:0] target_id;
    logic [15:0] callback_tag;
    logic [31:0] argument;
  } cmd_t;

  // Result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [30:0] timer_id;
    logic [15:0] fired_tag;
    logic [31:0] fired_argument;
    logic        last;
  } res_t;

  // One stored timer.
  typedef struct packed {
    logic [31:0] deadline;
    logic [30:0] id;
    logic [15:0] tag;
    logic [31:0] arg;
  } entry_t;

  // Update request to the entry table.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
  } ent_op_t;

  // Outcome of the shared comparator.
  typedef struct packed {
    logic later;
    logic equal;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: sv/sorted_deadline_timer_queue.sv
// Usage: sorted deadline timer queue.
// The cmd channel (cmd_valid, cmd_ready, cmd) takes one item at a time: add a
// timer, delete a timer by id, or a one millisecond tick. The res channel
// (res_valid, res_ready, res) returns results, with last set on the final one
// an item causes; a tick with nothing due, or an unused command, gives none.
// cmd_ready is high only while the sequencer is idle with no result pending.
// An add walks the sorted table one entry per cycle through the shared
// comparator until it finds its slot. A delete walks until the id matches
// or the end of the table is reached. A zero delay or a full queue is
// answered straight from the idle state, with no walk. A tick pops each due
// entry in turn, holding the latest one back so that last can be set, and
// stops at the first entry that is not due; at most 16 expiries fire per
// tick.
// Every result waits in the output register until taken; while res_ready is
// low the sequencer holds and nothing else advances.
// Reset clears time, the id counter and the fill count; the entry table
// itself needs no clearing.
`default_nettype none

module sorted_deadline_timer_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire sdtq_pkg::cmd_t   cmd,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output sdtq_pkg::res_t        res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_TICK = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                         state;
  logic [31:0]                    now;
  logic [30:0]                    next_id;
  logic [31:0]                    dl;
  logic [sdtq_pkg::CNT_W-1:0]     idx;
  logic [sdtq_pkg::FIRE_W-1:0]    fired;
  sdtq_pkg::cmd_t                 cmd_q;
  sdtq_pkg::entry_t               pend;
  logic                           pend_valid;
  logic                           ret_tick;

  sdtq_pkg::ent_op_t              op;
  sdtq_pkg::entry_t               new_entry;
  sdtq_pkg::entry_t               rd_entry;
  logic [sdtq_pkg::IDX_W-1:0]     rd_idx;
  logic [sdtq_pkg::CNT_W-1:0]     count;
  logic [31:0]                    cmp_a;
  logic [31:0]                    cmp_b;
  sdtq_pkg::cmp_res_t             cmp;

  logic scan_end;
  logic is_add;
  logic ins_hit;
  logic del_found;
  logic due;

  assign cmd_ready = (state == ST_IDLE);

  sdtq_entries u_entries (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .new_entry (new_entry),
    .rd_idx    (rd_idx),
    .rd_entry  (rd_entry),
    .count     (count)
  );

  sdtq_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  // Comparator operands and table requests for the current step.
  always_comb begin
    is_add    = (cmd_q.command == sdtq_pkg::CMD_ADD);
    scan_end  = (idx == count);
    rd_idx    = (state == ST_TICK) ? '0 : idx[sdtq_pkg::IDX_W-1:0];
    if (state == ST_TICK) begin
      cmp_a = rd_entry.deadline;
      cmp_b = now;
    end else if (is_add) begin
      cmp_a = rd_entry.deadline;
      cmp_b = dl;
    end else begin
      cmp_a = {1'b0, rd_entry.id};
      cmp_b = {1'b0, cmd_q.target_id};
    end
    ins_hit   = scan_end || cmp.later;
    del_found = !scan_end && cmp.equal;
    due       = (count != '0) && !cmp.later &&
                (fired != sdtq_pkg::FIRE_W'(sdtq_pkg::MAX_RESULTS));

    new_entry.deadline = dl;
    new_entry.id       = next_id;
    new_entry.tag      = cmd_q.callback_tag;
    new_entry.arg      = cmd_q.argument;

    op.ins = (state == ST_SCAN) && is_add && ins_hit;
    op.rem = ((state == ST_SCAN) && !is_add && del_found) ||
             ((state == ST_TICK) && due);
    op.pos = (state == ST_TICK) ? '0 : idx[sdtq_pkg::IDX_W-1:0];
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      now        <= '0;
      next_id    <= '0;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
      ret_tick   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_q    <= cmd;
            idx      <= '0;
            ret_tick <= 1'b0;
            unique case (cmd.command)
              sdtq_pkg::CMD_ADD: begin
                if (cmd.delay_ms == '0) begin
                  res       <= '{kind: sdtq_pkg::KIND_FIRED, timer_id: '0,
                                 fired_tag: cmd.callback_tag,
                                 fired_argument: cmd.argument, last: 1'b1};
                  res_valid <= 1'b1;
                  state     <= ST_EMIT;
                end else if (count == sdtq_pkg::CNT_W'(sdtq_pkg::DEPTH)) begin
                  res       <= '{kind: sdtq_pkg::KIND_FULL, timer_id: '0,
                                 fired_tag: '0, fired_argument: '0, last: 1'b1};
                  res_valid <= 1'b1;
                  state     <= ST_EMIT;
                end else begin
                  next_id <= next_id + 31'd1;
                  dl      <= now + {2'b00, cmd.delay_ms};
                  state   <= ST_SCAN;
                end
              end
              sdtq_pkg::CMD_DELETE: begin
                state <= ST_SCAN;
              end
              sdtq_pkg::CMD_TICK: begin
                now        <= now + 32'd1;
                fired      <= '0;
                pend_valid <= 1'b0;
                state      <= ST_TICK;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        // Walk the table one entry per cycle for an add or a delete.
        ST_SCAN: begin
          if (is_add) begin
            if (ins_hit) begin
              res       <= '{kind: sdtq_pkg::KIND_ADDED, timer_id: next_id,
                             fired_tag: '0, fired_argument: '0, last: 1'b1};
              res_valid <= 1'b1;
              state     <= ST_EMIT;
            end else begin
              idx <= idx + sdtq_pkg::CNT_W'(1);
            end
          end else if (scan_end) begin
            res       <= '{kind: sdtq_pkg::KIND_NOT_FOUND, timer_id: cmd_q.target_id,
                           fired_tag: '0, fired_argument: '0, last: 1'b1};
            res_valid <= 1'b1;
            state     <= ST_EMIT;
          end else if (cmp.equal) begin
            res       <= '{kind: sdtq_pkg::KIND_DELETED, timer_id: cmd_q.target_id,
                           fired_tag: '0, fired_argument: '0, last: 1'b1};
            res_valid <= 1'b1;
            state     <= ST_EMIT;
          end else begin
            idx <= idx + sdtq_pkg::CNT_W'(1);
          end
        end

        // Pop due entries; one is held back so that last can be set on the final one.
        ST_TICK: begin
          if (due) begin
            fired      <= fired + sdtq_pkg::FIRE_W'(1);
            pend       <= rd_entry;
            pend_valid <= 1'b1;
            if (pend_valid) begin
              res       <= '{kind: sdtq_pkg::KIND_FIRED, timer_id: pend.id,
                             fired_tag: pend.tag, fired_argument: pend.arg,
                             last: 1'b0};
              res_valid <= 1'b1;
              ret_tick  <= 1'b1;
              state     <= ST_EMIT;
            end
          end else if (pend_valid) begin
            res        <= '{kind: sdtq_pkg::KIND_FIRED, timer_id: pend.id,
                            fired_tag: pend.tag, fired_argument: pend.arg,
                            last: 1'b1};
            res_valid  <= 1'b1;
            pend_valid <= 1'b0;
            ret_tick   <= 1'b0;
            state      <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end

        // Hold the result until the receiver takes it.
        ST_EMIT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= ret_tick ? ST_TICK : ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/sdtq_cmp.sv
// Shared subtract-and-compare unit for deadline and id checks.
`default_nettype none

module sdtq_cmp (
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output sdtq_pkg::cmp_res_t     res
);

  logic [31:0] diff;

  // Modular compare: a is later than b when a - b is positive as a signed value.
  always_comb begin
    diff      = a - b;
    res.equal = (diff == 32'd0);
    res.later = (diff != 32'd0) && !diff[31];
  end

endmodule

`default_nettype wire

FILE: sv/sdtq_entries.sv
// Sorted timer entry table with insert and remove shifts and one read port.
`default_nettype none

module sdtq_entries (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sdtq_pkg::ent_op_t           op,
  input  wire sdtq_pkg::entry_t            new_entry,
  input  wire logic [sdtq_pkg::IDX_W-1:0]  rd_idx,
  output sdtq_pkg::entry_t                 rd_entry,
  output logic [sdtq_pkg::CNT_W-1:0]       count
);

  sdtq_pkg::entry_t ent [sdtq_pkg::DEPTH];

  // Read port for the sequencer.
  assign rd_entry = ent[rd_idx];

  // Insert opens a gap at pos by shifting up; remove closes it by shifting down.
  always_ff @(posedge clk) begin
    for (int i = 0; i < sdtq_pkg::DEPTH; i++) begin
      if (op.ins) begin
        if (i == int'(op.pos)) begin
          ent[i] <= new_entry;
        end else if (i > int'(op.pos)) begin
          ent[i] <= ent[(i > 0) ? i - 1 : 0];
        end
      end else if (op.rem) begin
        if (i >= int'(op.pos) && i < sdtq_pkg::DEPTH - 1) begin
          ent[i] <= ent[(i < sdtq_pkg::DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op.ins) begin
      count <= count + sdtq_pkg::CNT_W'(1);
    end else if (op.rem) begin
      count <= count - sdtq_pkg::CNT_W'(1);
    end
  end

endmodule

`default_nettype wire
